// File: rtl/audio_mix_filter_limit_assert.svh
// Assertion macros used by the checker file of the audio mix block.
`ifndef AUDIO_MIX_FILTER_LIMIT_ASSERT_SVH
`define AUDIO_MIX_FILTER_LIMIT_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold at that edge.
`define AMFL_ASSERT_IMP(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("audio mix block: same-cycle check failed");

// Next-cycle implication: when ante holds, cons must hold at the next edge.
`define AMFL_ASSERT_NXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("audio mix block: next-cycle check failed");

`endif

// File: rtl/amfl_pkg.sv
// Package with the shared types and constants of the audio mix block.
package amfl_pkg;

    // Field and state widths.
    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 9;
    localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;
    localparam int ACC_W      = 34;
    localparam int MIX_SHIFT  = 8;
    localparam int HIST_W     = ACC_W - MIX_SHIFT;
    localparam int SUM_W      = HIST_W + 2;
    localparam int ABS_W      = SUM_W - 1;
    localparam int INTEG_W    = 42;
    localparam int MODE_W     = 3;
    localparam int COEF_W     = 16;
    localparam int COEF_FRAC  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER_MODE = 2'd0,
        CFG_HP_COEF     = 2'd1,
        CFG_EIGHT_BIT   = 2'd2,
        CFG_SOUND_EN    = 2'd3
    } t_cfg_idx;

    // Lowpass mode codes; the codes above MODE_TRI pass the value through.
    localparam logic [MODE_W-1:0] MODE_NONE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_AVG2 = 3'd1;
    localparam logic [MODE_W-1:0] MODE_AVG3 = 3'd2;
    localparam logic [MODE_W-1:0] MODE_AVG4 = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TRI  = 3'd4;

    localparam logic [COEF_W-1:0] COEF_RESET = 16'd373;

    // Divide by three: floor(2^28 / 3), then one correction step.
    localparam int                DIV3_SHIFT = 28;
    localparam logic [ABS_W-1:0]  DIV3_MULT  = 27'd89478485;
    localparam int                Q3_W       = 2 * ABS_W - DIV3_SHIFT;

    // Output limits and 8-bit offset.
    localparam logic signed [SAMPLE_W-1:0] SAT16_MAX   = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAT16_MIN   = -16'sh8000;
    localparam logic [7:0]                 OUT8_OFFSET = 8'h80;
    localparam logic [SAMPLE_W-1:0]        SILENCE_8   = 16'd128;
    localparam logic [SAMPLE_W-1:0]        SILENCE_16  = 16'd0;

    // Integrator limits.
    localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

    // Configuration as seen by the filter back end.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [COEF_W-1:0] coef;
        logic              eight_bit;
        logic              sound_en;
    } t_cfg;

    // Sequencer states of the filter back end.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LP_SUM,
        ST_LP_MUL,
        ST_LP_DIV,
        ST_HP_DIFF,
        ST_HP_MUL,
        ST_HP_ACC,
        ST_HP_SAT,
        ST_EMIT
    } t_state;

endpackage

// File: rtl/audio_mix_filter_limit.sv
// Top level of the audio mix, lowpass, DC-cut and limit block.
//
// Input items arrive on a queue-like port: an item is taken at a clock edge
// with push high and full low. Each item carries one channel sample and its
// gain; the item with last_channel set closes one output sample.
// Results leave on a queue-like port: while empty is low the oldest result is
// on o_sample_out, and it is taken at an edge with pop high.
// Configuration registers are written over the cfg channel, which is always
// ready; write them only while no sample is in flight.
// The front end takes one item per cycle while full is low; a closed sample
// waits in a two-entry queue for the filter back end, whose sequencer runs
// the lowpass states (plus a multiply step in three-tap mode), the three
// passes of the shared 17-bit coefficient multiplier and the limiter, or
// skips to its emit state when sound is disabled. A result then waits in the
// output register. When pop stays low the result holds, the back end waits,
// and full rises once the queue and the product stage are both taken.
// Synchronous reset clears the mix sum, the filter history, the integrator,
// all pending items, and loads the register defaults.
module audio_mix_filter_limit
    import amfl_pkg::*;
#(
    parameter int HPF_FRACTION_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic signed [SAMPLE_W-1:0]   i_channel_sample,
    input  logic        [GAIN_W-1:0]     i_channel_gain,
    input  logic                         i_last_channel,
    output logic                         empty,
    input  logic                         pop,
    output logic signed [SAMPLE_W-1:0]   o_sample_out,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic        [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg             r_cfg;
    logic             front_valid;
    logic             front_ready;
    logic [ACC_W-1:0] front_sum;
    logic             back_valid;
    logic             back_ready;
    logic [ACC_W-1:0] back_sum;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{mode: MODE_NONE, coef: COEF_RESET, eight_bit: 1'b0, sound_en: 1'b1};
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FILTER_MODE: r_cfg.mode      <= i_cfg_data[MODE_W-1:0];
                CFG_HP_COEF:     r_cfg.coef      <= i_cfg_data[COEF_W-1:0];
                CFG_EIGHT_BIT:   r_cfg.eight_bit <= i_cfg_data[0];
                CFG_SOUND_EN:    r_cfg.sound_en  <= i_cfg_data[0];
            endcase
        end
    end

    // Mixing front end.
    amfl_mix_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_channel_sample (i_channel_sample),
        .i_channel_gain   (i_channel_gain),
        .i_last_channel   (i_last_channel),
        .o_sum_valid      (front_valid),
        .i_sum_ready      (front_ready),
        .o_sum            (front_sum)
    );

    // Queue of closed mix sums.
    amfl_queue #(
        .WIDTH (ACC_W)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (front_valid),
        .o_wr_ready (front_ready),
        .i_wr_data  (front_sum),
        .o_rd_valid (back_valid),
        .i_rd_ready (back_ready),
        .o_rd_data  (back_sum)
    );

    // Filter and limiter back end.
    amfl_filter_back #(
        .FRAC_BITS (HPF_FRACTION_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_sum_valid  (back_valid),
        .o_sum_ready  (back_ready),
        .i_sum        (back_sum),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_sample_out (o_sample_out)
    );

endmodule

// File: rtl/amfl_queue.sv
// Two-entry first-in first-out queue in flip-flops.
module amfl_queue #(
    parameter int WIDTH = 34
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_valid,
    output logic             o_wr_ready,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_rd_valid,
    input  logic             i_rd_ready,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_wr_ready = (r_count != 2'd2);
    assign o_rd_valid = (r_count != 2'd0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign wr_en      = i_wr_valid && o_wr_ready;
    assign rd_en      = i_rd_ready && o_rd_valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (rd_en) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

// File: rtl/amfl_mix_front.sv
// Front end: takes channel items, multiplies sample by gain and sums a mix.
module amfl_mix_front
    import amfl_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    output logic                       o_full,
    input  logic signed [SAMPLE_W-1:0] i_channel_sample,
    input  logic        [GAIN_W-1:0]   i_channel_gain,
    input  logic                       i_last_channel,
    output logic                       o_sum_valid,
    input  logic                       i_sum_ready,
    output logic        [ACC_W-1:0]    o_sum
);

    logic                     r_pv;
    logic                     r_plast;
    logic signed [PROD_W-1:0] r_prod;
    logic        [ACC_W-1:0]  r_acc;
    logic signed [PROD_W-1:0] prod;
    logic        [ACC_W-1:0]  acc_sum;
    logic                     adv;
    logic                     accept;

    // The product stage leaves when it is no last item or the queue has room.
    assign adv     = r_pv && (!r_plast || i_sum_ready);
    assign o_full  = r_pv && !adv;
    assign accept  = i_push && !o_full;
    assign prod    = i_channel_sample * $signed({1'b0, i_channel_gain});
    assign acc_sum = r_acc + ACC_W'(r_prod);

    assign o_sum_valid = r_pv && r_plast;
    assign o_sum       = acc_sum;

    // Stage valid and running sum; the sum restarts after each last item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv  <= 1'b0;
            r_acc <= '0;
        end else begin
            r_pv <= accept || (r_pv && !adv);
            if (adv) begin
                r_acc <= r_plast ? '0 : acc_sum;
            end
        end
    end

    // Product register.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prod  <= prod;
            r_plast <= i_last_channel;
        end
    end

endmodule

// File: rtl/amfl_filter_back.sv
// Back end: lowpass, DC-cut high-pass, limiter and the output register.
module amfl_filter_back
    import amfl_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cfg                       i_cfg,
    input  logic                       i_sum_valid,
    output logic                       o_sum_ready,
    input  logic        [ACC_W-1:0]    i_sum,
    output logic                       o_empty,
    input  logic                       i_pop,
    output logic signed [SAMPLE_W-1:0] o_sample_out
);

    // Difference width, limb layout of the coefficient product, step width.
    localparam int DW = ((HIST_W + FRAC_BITS > INTEG_W) ? HIST_W + FRAC_BITS : INTEG_W) + 1;
    localparam int LW = DW - 2 * COEF_FRAC;
    localparam int BW = (LW > COEF_W + 1) ? LW : COEF_W + 1;
    localparam int PW = COEF_W + 1 + BW;
    localparam int SW = DW + 1;
    localparam int TW = DW - FRAC_BITS;
    localparam logic [DW-1:0] FRAC_MASK = DW'((64'd1 << FRAC_BITS) - 64'd1);

    t_state                    r_state;
    t_state                    n_state;
    logic signed [HIST_W-1:0]  r_x;
    logic signed [HIST_W-1:0]  r_y;
    logic signed [HIST_W-1:0]  r_h0;
    logic signed [HIST_W-1:0]  r_h1;
    logic signed [HIST_W-1:0]  r_h2;
    logic signed [INTEG_W-1:0] r_integ;
    logic signed [SUM_W-1:0]   r_sum;
    logic        [ABS_W-1:0]   r_abs;
    logic                      r_neg;
    logic        [2*ABS_W-1:0] r_q3prod;
    logic signed [DW-1:0]      r_d;
    logic        [1:0]         r_limb;
    logic signed [PW-1:0]      r_prod;
    logic signed [SW-1:0]      r_step;
    logic        [SAMPLE_W-1:0] r_res;
    logic                      r_out_valid;
    logic        [SAMPLE_W-1:0] r_out_data;

    logic                      out_load;
    logic signed [SUM_W-1:0]   lp_sum;
    logic signed [SUM_W-1:0]   lp_abs_full;
    logic signed [SUM_W-1:0]   adj2;
    logic signed [SUM_W-1:0]   adj4;
    logic        [Q3_W-1:0]    q0;
    logic        [ABS_W:0]     q0x3;
    logic        [ABS_W:0]     rem3;
    logic        [Q3_W-1:0]    q3;
    logic signed [HIST_W-1:0]  y3;
    logic signed [HIST_W-1:0]  lp_y;
    logic signed [DW-1:0]      y_shift;
    logic signed [BW-1:0]      limb_b;
    logic signed [LW-1:0]      d_hi;
    logic signed [SW:0]        isum;
    logic signed [INTEG_W-1:0] integ_next;
    logic        [DW-1:0]      d_adj;
    logic signed [TW-1:0]      hp_t;
    logic signed [SAMPLE_W-1:0] y16;
    logic        [SAMPLE_W-1:0] res_fmt;

    // Lowpass tap sum by mode.
    always_comb begin
        case (i_cfg.mode)
            MODE_AVG2: lp_sum = SUM_W'(r_h0) + SUM_W'(r_x);
            MODE_AVG3: lp_sum = SUM_W'(r_h1) + SUM_W'(r_h0) + SUM_W'(r_x);
            MODE_AVG4: lp_sum = SUM_W'(r_h2) + SUM_W'(r_h1) + SUM_W'(r_h0) + SUM_W'(r_x);
            MODE_TRI:  lp_sum = SUM_W'(r_h1) + (SUM_W'(r_h0) <<< 1) + SUM_W'(r_x);
            default:   lp_sum = SUM_W'(r_x);
        endcase
        lp_abs_full = lp_sum[SUM_W-1] ? -lp_sum : lp_sum;
    end

    // Truncating divides of the tap sum by two, three and four.
    always_comb begin
        adj2 = r_sum + (r_neg ? SUM_W'(1) : SUM_W'(0));
        adj4 = r_sum + (r_neg ? SUM_W'(3) : SUM_W'(0));
        q0   = r_q3prod[DIV3_SHIFT +: Q3_W];
        q0x3 = {1'b0, q0, 1'b0} + {2'b00, q0};
        rem3 = {1'b0, r_abs} - q0x3;
        q3   = q0 + ((rem3 >= (ABS_W+1)'(3)) ? Q3_W'(1) : Q3_W'(0));
        y3   = r_neg ? $signed(~q3 + Q3_W'(1)) : $signed(q3);
        case (i_cfg.mode) inside
            MODE_AVG2:           lp_y = adj2[HIST_W:1];
            MODE_AVG3:           lp_y = y3;
            MODE_AVG4, MODE_TRI: lp_y = adj4[HIST_W+1:2];
            default:             lp_y = r_x;
        endcase
    end

    // High-pass difference input and coefficient limb select.
    always_comb begin
        y_shift = DW'(r_y) <<< FRAC_BITS;
        d_hi    = r_d[DW-1:2*COEF_FRAC];
        case (r_limb)
            2'd0:    limb_b = BW'(r_d[COEF_FRAC-1:0]);
            2'd1:    limb_b = BW'(r_d[2*COEF_FRAC-1:COEF_FRAC]);
            default: limb_b = BW'(d_hi);
        endcase
    end

    // Integrator saturation, truncated output, limiter and output format.
    always_comb begin
        isum = (SW+1)'(r_integ) + (SW+1)'(r_step);
        if (isum > (SW+1)'(INTEG_MAX)) begin
            integ_next = INTEG_MAX;
        end else if (isum < (SW+1)'(INTEG_MIN)) begin
            integ_next = INTEG_MIN;
        end else begin
            integ_next = isum[INTEG_W-1:0];
        end
        d_adj = r_d + (r_d[DW-1] ? FRAC_MASK : '0);
        hp_t  = $signed(d_adj[DW-1:FRAC_BITS]);
        if (hp_t > TW'(SAT16_MAX)) begin
            y16 = SAT16_MAX;
        end else if (hp_t < TW'(SAT16_MIN)) begin
            y16 = SAT16_MIN;
        end else begin
            y16 = hp_t[SAMPLE_W-1:0];
        end
        res_fmt = i_cfg.eight_bit ? {8'h00, y16[SAMPLE_W-1:8] ^ OUT8_OFFSET} : y16;
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_sum_valid) begin
                    n_state = i_cfg.sound_en ? ST_LP_SUM : ST_EMIT;
                end
            end
            ST_LP_SUM:  n_state = (i_cfg.mode == MODE_AVG3) ? ST_LP_MUL : ST_LP_DIV;
            ST_LP_MUL:  n_state = ST_LP_DIV;
            ST_LP_DIV:  n_state = ST_HP_DIFF;
            ST_HP_DIFF: n_state = ST_HP_MUL;
            ST_HP_MUL:  n_state = ST_HP_ACC;
            ST_HP_ACC:  n_state = (r_limb == 2'd2) ? ST_HP_SAT : ST_HP_MUL;
            ST_HP_SAT:  n_state = ST_EMIT;
            ST_EMIT: begin
                if (!r_out_valid || i_pop) begin
                    n_state = ST_IDLE;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_sum_ready = 1'b0;
        out_load    = 1'b0;
        unique case (r_state)
            ST_IDLE: o_sum_ready = 1'b1;
            ST_EMIT: out_load    = !r_out_valid || i_pop;
            default: begin
                o_sum_ready = 1'b0;
                out_load    = 1'b0;
            end
        endcase
    end

    // State register and filter state; history and integrator reset to zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_h0    <= '0;
            r_h1    <= '0;
            r_h2    <= '0;
            r_integ <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_LP_DIV) begin
                case (i_cfg.mode) inside
                    MODE_AVG2: r_h0 <= lp_y;
                    MODE_AVG3, MODE_TRI: begin
                        r_h1 <= r_h0;
                        r_h0 <= lp_y;
                    end
                    MODE_AVG4: begin
                        r_h2 <= r_h1;
                        r_h1 <= r_h0;
                        r_h0 <= lp_y;
                    end
                    default: r_h0 <= r_h0;
                endcase
            end
            if (r_state == ST_HP_SAT) begin
                r_integ <= integ_next;
            end
        end
    end

    // Datapath registers stepped by the sequencer.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_x   <= i_sum[ACC_W-1:MIX_SHIFT];
                r_res <= i_cfg.eight_bit ? SILENCE_8 : SILENCE_16;
            end
            ST_LP_SUM: begin
                r_sum <= lp_sum;
                r_neg <= lp_sum[SUM_W-1];
                r_abs <= lp_abs_full[ABS_W-1:0];
            end
            ST_LP_MUL: r_q3prod <= r_abs * DIV3_MULT;
            ST_LP_DIV: r_y <= lp_y;
            ST_HP_DIFF: begin
                r_d    <= y_shift - DW'(r_integ);
                r_limb <= 2'd0;
                r_step <= '0;
            end
            ST_HP_MUL: r_prod <= $signed({1'b0, i_cfg.coef}) * limb_b;
            ST_HP_ACC: begin
                case (r_limb)
                    2'd0: r_step <= r_step + SW'(r_prod[2*COEF_FRAC-1:COEF_FRAC]);
                    2'd1: r_step <= r_step + SW'(r_prod);
                    default: r_step <= r_step + (SW'(r_prod) <<< COEF_FRAC);
                endcase
                r_limb <= r_limb + 2'd1;
            end
            ST_HP_SAT: r_res <= res_fmt;
            default: r_res <= r_res;
        endcase
    end

    // Output register: holds a finished item until it is popped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= r_res;
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_sample_out = $signed(r_out_data);

endmodule

// File: rtl/amfl_checker.sv
// Port-level checker for the audio mix block and its bind statement.
`include "audio_mix_filter_limit_assert.svh"

module amfl_checker
    import amfl_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       push,
    input logic                       full,
    input logic                       i_last_channel,
    input logic                       empty,
    input logic                       pop,
    input logic signed [SAMPLE_W-1:0] o_sample_out
);

    logic [7:0] r_pending;
    logic       last_in;
    logic       res_out;

    assign last_in = push && !full && i_last_channel;
    assign res_out = pop && !empty;

    // Count of closed samples whose result has not been popped yet.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 8'd0;
        end else begin
            case ({last_in, res_out})
                2'b10:   r_pending <= r_pending + 8'd1;
                2'b01:   r_pending <= r_pending - 8'd1;
                default: r_pending <= r_pending;
            endcase
        end
    end

    // Reset leaves no result waiting and the input open.
    `AMFL_ASSERT_NXT(a_reset_clears, i_clk, !i_rst_n, empty && !full)
    // A waiting result holds while it is not popped.
    `AMFL_ASSERT_NXT(a_out_hold, i_clk, i_rst_n && !empty && !pop, !empty && $stable(o_sample_out))
    // A result is shown only for a closed sample.
    `AMFL_ASSERT_IMP(a_out_has_source, i_clk, i_rst_n && !empty, r_pending != 8'd0)
    // A newly closed sample cannot reach the output in the next cycle.
    `AMFL_ASSERT_NXT(a_no_instant, i_clk, i_rst_n && res_out && r_pending == 8'd1, empty)

endmodule

bind audio_mix_filter_limit amfl_checker u_amfl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .push           (push),
    .full           (full),
    .i_last_channel (i_last_channel),
    .empty          (empty),
    .pop            (pop),
    .o_sample_out   (o_sample_out)
);
